FILE: src/i2c_rwc_pkg.sv
// ----------------------------------------------------------------------------
// i2c_rwc_pkg
// shared step codes, field widths and line-level type for the smbus
// read-word-with-check i2c master
// ----------------------------------------------------------------------------
package i2c_rwc_pkg;

   localparam int unsigned STEP_W   = 5;
   localparam int unsigned PHASE_W  = 16;
   localparam int unsigned BIT_CNT_W = 4;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned ADDR_W   = 7;

   localparam int unsigned REQ_DATA_W = 24;   // 17 field bits padded to bytes
   localparam int unsigned RSP_DATA_W = 32;   // 28 field bits padded to bytes

   // sequence steps
   localparam logic [STEP_W-1:0] STEP_IDLE    = 5'd0;
   localparam logic [STEP_W-1:0] STEP_START   = 5'd1;
   localparam logic [STEP_W-1:0] STEP_AW      = 5'd2;    // address+write, command
   localparam logic [STEP_W-1:0] STEP_AW_LAST = 5'd9;
   localparam logic [STEP_W-1:0] STEP_CMD_GO  = 5'd5;    // end of address+write byte
   localparam logic [STEP_W-1:0] STEP_RS_LOW  = 5'd10;
   localparam logic [STEP_W-1:0] STEP_RS_HIGH = 5'd11;
   localparam logic [STEP_W-1:0] STEP_RS_SDA  = 5'd12;
   localparam logic [STEP_W-1:0] STEP_AR      = 5'd13;
   localparam logic [STEP_W-1:0] STEP_RX      = 5'd17;
   localparam logic [STEP_W-1:0] STEP_SP_LOW  = 5'd29;
   localparam logic [STEP_W-1:0] STEP_SP_HIGH = 5'd30;
   localparam logic [STEP_W-1:0] STEP_SP_REL  = 5'd31;

   localparam logic [PHASE_W-1:0]   PHASE_TICKS_RESET = 16'd20;
   localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE     = 4'd8;

   // sub-phase within one bit slot
   localparam logic [1:0] SUB_SCL_HIGH = 2'd1;
   localparam logic [1:0] SUB_ACK_HIGH = 2'd3;

   typedef struct packed {
      logic scl;
      logic pull;
   } line_type;

endpackage

FILE: src/i2c_rwc_drive.sv
// ----------------------------------------------------------------------------
// i2c_rwc_drive
// decodes the current sequence step into the scl level and sda pull-down
// ----------------------------------------------------------------------------
module i2c_rwc_drive (
   input  logic [i2c_rwc_pkg::STEP_W-1:0] step,
   input  logic                           tx_bit,   // msb of the shift register
   output i2c_rwc_pkg::line_type          lines
);
   import i2c_rwc_pkg::*;

   logic [STEP_W-1:0] tx_off;
   logic [STEP_W-1:0] rx_off;

   always_comb begin
      tx_off = (step >= STEP_AR) ? (step - STEP_AR) : (step - STEP_AW);
      rx_off = step - STEP_RX;
      lines.scl  = 1'b1;
      lines.pull = 1'b0;
      if (step == STEP_IDLE) begin
         lines.scl  = 1'b1;
         lines.pull = 1'b0;
      end else if (step == STEP_START) begin
         lines.scl  = 1'b1;
         lines.pull = 1'b1;
      end else if ((step >= STEP_AW && step <= STEP_AW_LAST) ||
                   (step >= STEP_AR && step < STEP_RX)) begin
         lines.scl  = tx_off[0];
         lines.pull = tx_off[1] ? 1'b0 : ~tx_bit;   // ack slot releases sda
      end else if (step == STEP_RS_LOW) begin
         lines.scl  = 1'b0;
         lines.pull = 1'b0;
      end else if (step == STEP_RS_HIGH) begin
         lines.scl  = 1'b1;
         lines.pull = 1'b0;
      end else if (step == STEP_RS_SDA) begin
         lines.scl  = 1'b1;
         lines.pull = 1'b1;
      end else if (step >= STEP_RX && step < STEP_SP_LOW) begin
         // master acks the first two bytes, nacks the check byte
         lines.scl  = rx_off[0];
         lines.pull = rx_off[1] ? (rx_off[3:2] < 2'd2) : 1'b0;
      end else if (step == STEP_SP_LOW) begin
         lines.scl  = 1'b0;
         lines.pull = 1'b1;
      end else if (step == STEP_SP_HIGH) begin
         lines.scl  = 1'b1;
         lines.pull = 1'b1;
      end
   end

endmodule

FILE: src/i2c_master_read_word_with_check_unit.sv
// ----------------------------------------------------------------------------
// i2c_master_read_word_with_check_unit
// tick-driven i2c master running one smbus read-word-with-check transaction
// ----------------------------------------------------------------------------
// a result item appears on rsp in the cycle after its tick item is taken
// throughput: one tick item per cycle while rsp is not stalled, set by the single state update pass
// the result register is freed in the same cycle it is taken, so no bubbles
// reset: synchronous, active high; sequencer idle, counters and bytes zero,
// phase length back to 20 ticks, no result pending, no item taken in reset
module i2c_master_read_word_with_check_unit (
   input  logic                                clock,
   input  logic                                reset,
   // slave side tick items
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [0] start_request, [7:1] device_address, [15:8] command_code,
   // [16] sda_sample, [23:17] zero
   input  logic [i2c_rwc_pkg::REQ_DATA_W-1:0]  req_tdata,
   // master side result items
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res,
   // [11:4] data_low, [19:12] data_high, [27:20] data_check, [31:28] zero
   output logic [i2c_rwc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // phase length register write
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [i2c_rwc_pkg::PHASE_W-1:0]     csr_data
);
   import i2c_rwc_pkg::*;

   // request fields
   logic                 start_request;
   logic [ADDR_W-1:0]    device_address;
   logic [BYTE_W-1:0]    command_code;
   logic                 sda_sample;
   logic                 accept;

   // sequencer state
   logic [STEP_W-1:0]    step_ff, step_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [BYTE_W-1:0]    shift_ff, shift_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [BYTE_W-1:0]    cmd_ff, cmd_in;
   logic [BYTE_W-1:0]    data_low_ff, data_low_in;
   logic [BYTE_W-1:0]    data_high_ff, data_high_in;
   logic [BYTE_W-1:0]    data_check_ff, data_check_in;
   logic [PHASE_W-1:0]   phase_ticks_ff;

   // result register
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // working values for this tick
   logic [STEP_W-1:0]    cur_step;
   logic [BYTE_W-1:0]    cur_shift;
   logic [BIT_CNT_W-1:0] cur_bit_cnt;
   logic [PHASE_W-1:0]   cur_phase;
   logic [PHASE_W-1:0]   phase_inc;
   logic [PHASE_W-1:0]   limit;
   logic [BIT_CNT_W-1:0] bit_inc;
   logic [BYTE_W-1:0]    rx_shift;
   logic [STEP_W-1:0]    tx_off;
   logic [STEP_W-1:0]    rx_off;
   logic                 busy;
   logic                 done;
   line_type             lines;

   assign start_request  = req_tdata[0];
   assign device_address = req_tdata[7:1];
   assign command_code   = req_tdata[15:8];
   assign sda_sample     = req_tdata[16];

   // the result register frees up in the same cycle it is drained
   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = !reset;

   // a phase length of zero behaves as one tick
   assign limit = (phase_ticks_ff == '0) ? {{(PHASE_W-1){1'b0}}, 1'b1} : phase_ticks_ff;

   // line levels come from the step as it stands after a start is taken
   i2c_rwc_drive u_drive (
      .step   (cur_step),
      .tx_bit (cur_shift[BYTE_W-1]),
      .lines  (lines)
   );

   always_comb begin
      // a start request only counts when idle
      cur_step    = step_ff;
      cur_shift   = shift_ff;
      cur_bit_cnt = bit_cnt_ff;
      cur_phase   = phase_ff;
      addr_in     = addr_ff;
      cmd_in      = cmd_ff;
      if (step_ff == STEP_IDLE && start_request) begin
         cur_step    = STEP_START;
         cur_shift   = '0;
         cur_bit_cnt = '0;
         cur_phase   = '0;
         addr_in     = device_address;
         cmd_in      = command_code;
      end

      step_in       = cur_step;
      shift_in      = cur_shift;
      bit_cnt_in    = cur_bit_cnt;
      phase_in      = cur_phase;
      data_low_in   = data_low_ff;
      data_high_in  = data_high_ff;
      data_check_in = data_check_ff;
      busy          = 1'b0;
      done          = 1'b0;

      phase_inc = cur_phase + 1'b1;
      bit_inc   = cur_bit_cnt + 1'b1;
      rx_shift  = {cur_shift[BYTE_W-2:0], sda_sample};
      tx_off    = (cur_step >= STEP_AR) ? (cur_step - STEP_AR) : (cur_step - STEP_AW);
      rx_off    = cur_step - STEP_RX;

      if (cur_step != STEP_IDLE) begin
         busy     = 1'b1;
         phase_in = phase_inc;
         if (phase_inc >= limit) begin
            // phase over: move the sequencer on
            phase_in = '0;
            if (cur_step == STEP_START) begin
               shift_in   = {addr_in, 1'b0};
               bit_cnt_in = '0;
               step_in    = STEP_AW;
            end else if ((cur_step >= STEP_AW && cur_step <= STEP_AW_LAST) ||
                         (cur_step >= STEP_AR && cur_step < STEP_RX)) begin
               // transmit byte: two sub-phases per bit plus a two-sub-phase ack slot, ack ignored
               if (tx_off[1:0] == SUB_SCL_HIGH) begin
                  shift_in   = {cur_shift[BYTE_W-2:0], 1'b0};
                  bit_cnt_in = bit_inc;
                  step_in    = (bit_inc >= BITS_PER_BYTE) ? cur_step + 1'b1
                                                          : cur_step - 1'b1;
               end else if (tx_off[1:0] == SUB_ACK_HIGH) begin
                  bit_cnt_in = '0;
                  if (cur_step == STEP_CMD_GO) begin
                     shift_in = cmd_in;
                     step_in  = cur_step + 1'b1;
                  end else if (cur_step == STEP_AW_LAST) begin
                     step_in  = STEP_RS_LOW;
                  end else begin
                     shift_in = '0;
                     step_in  = STEP_RX;
                  end
               end else begin
                  step_in = cur_step + 1'b1;
               end
            end else if (cur_step == STEP_RS_LOW || cur_step == STEP_RS_HIGH) begin
               step_in = cur_step + 1'b1;
            end else if (cur_step == STEP_RS_SDA) begin
               shift_in   = {addr_in, 1'b1};
               bit_cnt_in = '0;
               step_in    = STEP_AR;
            end else if (cur_step >= STEP_RX && cur_step < STEP_SP_LOW) begin
               // receive byte, sampled at the end of scl high
               if (rx_off[1:0] == SUB_SCL_HIGH) begin
                  shift_in   = rx_shift;
                  bit_cnt_in = bit_inc;
                  if (bit_inc >= BITS_PER_BYTE) begin
                     case (rx_off[3:2])
                        2'd0:    data_low_in   = rx_shift;
                        2'd1:    data_high_in  = rx_shift;
                        2'd2:    data_check_in = rx_shift;
                        default: data_low_in   = data_low_ff;
                     endcase
                     step_in = cur_step + 1'b1;
                  end else begin
                     step_in = cur_step - 1'b1;
                  end
               end else if (rx_off[1:0] == SUB_ACK_HIGH) begin
                  bit_cnt_in = '0;
                  shift_in   = '0;
                  step_in    = cur_step + 1'b1;
               end else begin
                  step_in = cur_step + 1'b1;
               end
            end else if (cur_step == STEP_SP_LOW || cur_step == STEP_SP_HIGH) begin
               step_in = cur_step + 1'b1;
            end else begin
               // stop released: transaction complete
               step_in = STEP_IDLE;
               done    = 1'b1;
            end
         end
      end

      rsp_data_in = {4'd0, data_check_in, data_high_in, data_low_in,
                     done, busy, lines.pull, lines.scl};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= STEP_IDLE;
         phase_ff       <= '0;
         bit_cnt_ff     <= '0;
         shift_ff       <= '0;
         addr_ff        <= '0;
         cmd_ff         <= '0;
         data_low_ff    <= '0;
         data_high_ff   <= '0;
         data_check_ff  <= '0;
         phase_ticks_ff <= PHASE_TICKS_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            phase_ticks_ff <= csr_data;
         end
         if (accept) begin
            step_ff       <= step_in;
            phase_ff      <= phase_in;
            bit_cnt_ff    <= bit_cnt_in;
            shift_ff      <= shift_in;
            addr_ff       <= addr_in;
            cmd_ff        <= cmd_in;
            data_low_ff   <= data_low_in;
            data_high_ff  <= data_high_in;
            data_check_ff <= data_check_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef ASSERT_OFF
   // a finished transaction leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      accept && done |=> step_ff == STEP_IDLE)
      else $error("sequencer not idle after stop");

   // the phase counter rests at zero whenever idle
   assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_IDLE |-> phase_ff == '0)
      else $error("phase counter not cleared while idle");

   // never more than eight bits counted in one byte
   assert property (@(posedge clock) disable iff (reset)
      bit_cnt_ff <= BITS_PER_BYTE)
      else $error("bit counter overran a byte");

   // a result that reports done also reports busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[3] |-> rsp_data_ff[2])
      else $error("done reported without busy");
`endif

endmodule
